### rtl/ibtb_pkg.sv
// Package for the blocklist / token bucket filter: field widths, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package ibtb_pkg;
  localparam int TABLE_SLOTS_DEF = 16;
  localparam int NUM_STATS = 6;
  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [33:0] REFILL_CAP = 34'h2_0000_0000;
  // 1e9 = 2^9 * NS_DIV_ODD; RECIP_ODD = floor(2^52 / NS_DIV_ODD).
  localparam logic [20:0] NS_DIV_ODD = 21'd1953125;
  localparam logic [31:0] RECIP_ODD = 32'd2305843009;
  // 2^32 * 1e9: products at or above this give a refill of 2^32 or more.
  localparam logic [95:0] REFILL_BIG = 96'h3B9A_CA00_0000_0000;

  typedef enum logic [1:0] {
    MODE_PKT = 2'd0, MODE_WRITE = 2'd1, MODE_READ = 2'd2, MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CAUSE_NONE = 2'd0, CAUSE_BLOCKED = 2'd1, CAUSE_TOKENS = 2'd2, CAUSE_RSVD = 2'd3
  } cause_t;

  localparam logic [2:0] ST_TOTAL = 3'd0;
  localparam logic [2:0] ST_ALLOWED = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_LIMITED = 3'd3;
  localparam logic [2:0] ST_BYTES_OK = 3'd4;
  localparam logic [2:0] ST_BYTES_DROP = 3'd5;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic        blocked;
    logic        limited;
    logic [31:0] rate;
    logic [31:0] burst;
    logic [31:0] tokens;
    logic [63:0] last;
  } entry_t;

  // Token passed along the search chain.
  typedef struct packed {
    logic        busy;
    logic        hit;
    logic [31:0] key;
  } probe_t;
endpackage

### rtl/ibtb_cell.sv
// One table slot: holds one entry, compares the passing probe against it and
// hands the probe to the next cell. Depends on ibtb_pkg.
`timescale 1ns / 1ps
module ibtb_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  ibtb_pkg::entry_t wr_entry,
  input  ibtb_pkg::probe_t probe_in,
  output ibtb_pkg::probe_t probe_out,
  output logic            match,
  output ibtb_pkg::entry_t entry
);
  import ibtb_pkg::*;
  entry_t ent_r;
  logic   val_r;
  probe_t probe_r, probe_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
      if (wr_en) begin
        val_r <= wr_entry.valid;
      end
    end
    if (wr_en) begin
      ent_r <= wr_entry;
    end
  end

  assign match = probe_in.busy && !probe_in.hit && val_r && (ent_r.key == probe_in.key);
  assign probe_out = probe_r;

  always_comb begin
    probe_nxt = probe_in;
    if (match) probe_nxt.hit = 1'b1;
    entry = ent_r;
    entry.valid = val_r;
  end
endmodule

### rtl/ibtb_refill.sv
// Refill unit: floor(elapsed*rate/1e9), or 2^33 once that reaches 2^32, by a shared 32x32
// multiplier and a reciprocal multiply with correction. Depends on ibtb_pkg.
`timescale 1ns / 1ps
module ibtb_refill (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] elapsed,
  input  logic [31:0] rate,
  output logic        done,
  output logic [33:0] amount
);
  import ibtb_pkg::*;

  typedef enum logic [6:0] {
    R_IDLE = 7'b0000001, R_PLO = 7'b0000010, R_PHI = 7'b0000100, R_RLO = 7'b0001000,
    R_RHI = 7'b0010000, R_QMUL = 7'b0100000, R_FIX = 7'b1000000
  } refill_ph_t;

  refill_ph_t  ph_r, ph_nxt;
  logic [63:0] el_r;
  logic [31:0] rt_r;
  logic [95:0] prod_r, prod_nxt;
  logic [52:0] x_r, x_nxt;
  logic [83:0] acc_r, acc_nxt;
  logic [31:0] q_r, q_nxt;
  logic [52:0] qd_r, qd_nxt;
  logic        big_r, big_nxt;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [52:0] rem;
  logic [31:0] q_fix;

  always_comb begin
    case (ph_r)
      R_PLO: begin
        mul_a = el_r[31:0]; mul_b = rt_r;
      end
      R_PHI: begin
        mul_a = el_r[63:32]; mul_b = rt_r;
      end
      R_RLO: begin
        mul_a = prod_r[40:9]; mul_b = RECIP_ODD;
      end
      R_RHI: begin
        mul_a = {11'd0, x_r[52:32]}; mul_b = RECIP_ODD;
      end
      R_QMUL: begin
        mul_a = acc_r[83:52]; mul_b = {11'd0, NS_DIV_ODD};
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    prod_nxt = prod_r;
    x_nxt = x_r;
    acc_nxt = acc_r;
    q_nxt = q_r;
    qd_nxt = qd_r;
    big_nxt = big_r;
    ph_nxt = ph_r;
    done = 1'b0;
    case (ph_r)
      R_IDLE: begin
        if (start) ph_nxt = R_PLO;
      end
      R_PLO: begin
        prod_nxt = {32'd0, mul_p};
        ph_nxt = R_PHI;
      end
      R_PHI: begin
        prod_nxt = prod_r + {mul_p, 32'd0};
        ph_nxt = R_RLO;
      end
      R_RLO: begin
        big_nxt = (prod_r >= REFILL_BIG);
        x_nxt = prod_r[61:9];
        acc_nxt = {20'd0, mul_p};
        ph_nxt = R_RHI;
      end
      R_RHI: begin
        acc_nxt = acc_r + {mul_p[51:0], 32'd0};
        ph_nxt = R_QMUL;
      end
      R_QMUL: begin
        q_nxt = acc_r[83:52];
        qd_nxt = mul_p[52:0];
        ph_nxt = R_FIX;
      end
      R_FIX: begin
        done = 1'b1;
        ph_nxt = R_IDLE;
      end
      default: ph_nxt = R_IDLE;
    endcase
  end

  assign rem = x_r - qd_r;
  assign q_fix = (rem >= {31'd0, NS_DIV_ODD, 1'b0}) ? q_r + 32'd2
               : (rem >= {32'd0, NS_DIV_ODD}) ? q_r + 32'd1 : q_r;
  assign amount = big_r ? REFILL_CAP : {2'd0, q_fix};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= R_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
    prod_r <= prod_nxt;
    x_r <= x_nxt;
    acc_r <= acc_nxt;
    q_r <= q_nxt;
    qd_r <= qd_nxt;
    big_r <= big_nxt;
    if (start && ph_r == R_IDLE) begin
      el_r <= elapsed;
      rt_r <= rate;
    end
  end
endmodule

### rtl/ip_blocklist_token_bucket_filter.sv
// Top level: slot chain, refill unit, counters and result register.
// Depends on ibtb_pkg, ibtb_cell, ibtb_refill.
//
// Usage: one item at a time on the in_ channel (valid/stall), one result per
// item on the out_ channel. mode 0 is a packet, 1 writes a table slot, 2 reads
// a counter. An IPv4 packet probe moves down the slot chain one cell per cycle
// until it hits or reaches the last slot, then a decide step; a bucket entry
// adds the refill (two product steps, a reciprocal multiply by 1/1e9 in two
// steps, a quotient step, a correction) and a write-back step. The result
// is offered in the cycle after that. Other items go straight to the result.
// No item is taken until the result of the last one has been taken, so
// receiver stalls hold off the input too. in_stall is high while an item
// is in progress or its result waits; out_valid holds with its payload
// until out_stall is low. Reset clears all slots to invalid and the six
// counters to zero; no clearing pass is needed.
`timescale 1ns / 1ps
module ip_blocklist_token_bucket_filter #(
  parameter int TABLE_SLOTS = ibtb_pkg::TABLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_src_ip,
  input  logic [15:0] in_pkt_len,
  input  logic [63:0] in_now_ns,
  input  logic        in_ipv4_ok,
  input  logic [3:0]  in_slot,
  input  logic        in_block_flag,
  input  logic        in_limit_enable,
  input  logic [31:0] in_rate,
  input  logic [31:0] in_burst,
  input  logic [31:0] in_start_tokens,
  input  logic [2:0]  in_stat_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verdict,
  output logic [1:0]  out_drop_cause,
  output logic [63:0] out_stat_value,
  output logic [31:0] out_tokens_left
);
  import ibtb_pkg::*;
  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SEARCH = 6'b000010, S_DECIDE = 6'b000100,
    S_REFILL = 6'b001000, S_SPEND = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] len_r;
  logic [63:0] now_r;
  logic [SW-1:0] cnt_r;
  logic        hit_r;
  logic [SW-1:0] hidx_r;
  entry_t      went_r;
  logic [63:0] stats_r [NUM_STATS];

  probe_t probe [TABLE_SLOTS+1];
  probe_t probe_r;
  logic [TABLE_SLOTS-1:0] match;
  entry_t ents [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] wr_en;
  entry_t wr_entry;
  entry_t spend_ent;

  logic        ref_start, ref_done;
  logic [33:0] ref_amt;
  logic [63:0] elapsed;

  logic        o_verdict;
  logic [1:0]  o_cause;
  logic [63:0] o_stat;
  logic [31:0] o_left;

  wire accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // Launch the probe into cell 0 on the first search cycle.
  assign probe[0] = '{busy: probe_r.busy && (state_r == S_SEARCH) && (cnt_r == '0),
                      hit: probe_r.hit, key: probe_r.key};

  generate
    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
      ibtb_cell u_cell (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en[g]), .wr_entry(wr_entry),
        .probe_in(probe[g]), .probe_out(probe[g+1]), .match(match[g]), .entry(ents[g])
      );
    end
  endgenerate

  // Write-back entry with spent token for SPEND.
  always_comb begin
    spend_ent = went_r;
    if (went_r.tokens != '0) spend_ent.tokens = went_r.tokens - 32'd1;
  end

  always_comb begin
    wr_en = '0;
    wr_entry = went_r;
    if (state_r == S_IDLE && accept && in_mode == MODE_WRITE
        && {28'd0, in_slot} < 32'(TABLE_SLOTS)) begin
      wr_en[in_slot[SW-1:0]] = 1'b1;
      wr_entry.valid = in_block_flag || in_limit_enable;
      wr_entry.key = in_src_ip;
      wr_entry.blocked = in_block_flag;
      wr_entry.limited = in_limit_enable;
      wr_entry.rate = in_rate;
      wr_entry.burst = in_burst;
      wr_entry.tokens = (in_start_tokens > in_burst) ? in_burst : in_start_tokens;
      wr_entry.last = in_now_ns;
    end else if (state_r == S_SPEND) begin
      wr_en[hidx_r] = 1'b1;
      wr_entry = spend_ent;
    end
  end

  assign elapsed = (now_r > went_r.last) ? now_r - went_r.last : 64'd0;
  assign ref_start = (state_r == S_DECIDE) && hit_r && !went_r.blocked && went_r.limited;

  ibtb_refill u_refill (
    .clk(clk), .rst_n(rst_n), .start(ref_start), .elapsed(elapsed),
    .rate(went_r.rate), .done(ref_done), .amount(ref_amt)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_PKT && in_ipv4_ok) state_nxt = S_SEARCH;
          else state_nxt = S_OUT;
        end
      end
      S_SEARCH: if (cnt_r == SW'(TABLE_SLOTS - 1) || match != '0) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = ref_start ? S_REFILL : S_OUT;
      S_REFILL: if (ref_done) state_nxt = S_SPEND;
      S_SPEND:  state_nxt = S_OUT;
      S_OUT:    if (!out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < NUM_STATS; i++) stats_r[i] <= '0;
      probe_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            len_r <= in_pkt_len; now_r <= in_now_ns;
            cnt_r <= '0; hit_r <= 1'b0;
            probe_r <= '{busy: 1'b1, hit: 1'b0, key: in_src_ip};
            o_verdict <= 1'b0; o_cause <= CAUSE_NONE; o_stat <= '0; o_left <= '0;
            if (in_mode == MODE_READ && in_stat_select < 3'(NUM_STATS))
              o_stat <= stats_r[in_stat_select];
          end
        end
        S_SEARCH: begin
          cnt_r <= cnt_r + SW'(1);
          if (match != '0) begin
            hit_r <= 1'b1;
            hidx_r <= cnt_r;
            went_r <= ents[cnt_r];
            probe_r.busy <= 1'b0;
          end
        end
        S_DECIDE: begin
          probe_r.busy <= 1'b0;
          stats_r[ST_TOTAL] <= stats_r[ST_TOTAL] + 64'd1;
          if (hit_r && went_r.blocked) begin
            o_verdict <= 1'b1; o_cause <= CAUSE_BLOCKED;
            stats_r[ST_BLOCKED] <= stats_r[ST_BLOCKED] + 64'd1;
            stats_r[ST_BYTES_DROP] <= stats_r[ST_BYTES_DROP] + {48'd0, len_r};
          end else if (!ref_start) begin
            stats_r[ST_ALLOWED] <= stats_r[ST_ALLOWED] + 64'd1;
            stats_r[ST_BYTES_OK] <= stats_r[ST_BYTES_OK] + {48'd0, len_r};
          end
        end
        S_REFILL: begin
          if (ref_done && ref_amt != '0) begin
            went_r.tokens <= ({2'd0, went_r.tokens} + ref_amt > {2'd0, went_r.burst})
                             ? went_r.burst : 32'(({2'd0, went_r.tokens} + ref_amt));
            went_r.last <= now_r;
          end
        end
        S_SPEND: begin
          if (went_r.tokens == '0) begin
            o_verdict <= 1'b1; o_cause <= CAUSE_TOKENS;
            stats_r[ST_LIMITED] <= stats_r[ST_LIMITED] + 64'd1;
            stats_r[ST_BYTES_DROP] <= stats_r[ST_BYTES_DROP] + {48'd0, len_r};
          end else begin
            o_left <= went_r.tokens - 32'd1;
            stats_r[ST_ALLOWED] <= stats_r[ST_ALLOWED] + 64'd1;
            stats_r[ST_BYTES_OK] <= stats_r[ST_BYTES_OK] + {48'd0, len_r};
          end
        end
        default: ;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = ^probe[TABLE_SLOTS];

  assign out_valid = (state_r == S_OUT);
  assign out_verdict = o_verdict;
  assign out_drop_cause = o_cause;
  assign out_stat_value = o_stat;
  assign out_tokens_left = o_left;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stat_value))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == (out_drop_cause != CAUSE_NONE)))
    else $error("verdict and cause disagree");
endmodule

### tb/ibtb_checker.sv
// Checker for the blocklist / token bucket filter: keeps its own copy of the slot table
// and counters, predicts each result and compares it with the out_ channel.
// Depends on ibtb_pkg.
`timescale 1ns / 1ps
module ibtb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_src_ip,
  input  logic [15:0] in_pkt_len,
  input  logic [63:0] in_now_ns,
  input  logic        in_ipv4_ok,
  input  logic [3:0]  in_slot,
  input  logic        in_block_flag,
  input  logic        in_limit_enable,
  input  logic [31:0] in_rate,
  input  logic [31:0] in_burst,
  input  logic [31:0] in_start_tokens,
  input  logic [2:0]  in_stat_select,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_verdict,
  input  logic [1:0]  out_drop_cause,
  input  logic [63:0] out_stat_value,
  input  logic [31:0] out_tokens_left,
  output int          fail_count,
  output int          pending
);
  import ibtb_pkg::*;

  typedef struct {
    logic        verdict;
    cause_t      cause;
    logic [63:0] value;
    logic [31:0] left;
  } verdict_t;

  entry_t      table_q[16];
  logic [63:0] counters[NUM_STATS];
  verdict_t    verdict_q[$];

  assign pending = verdict_q.size();

  function automatic logic [63:0] refill_tokens(logic [63:0] elapsed, logic [31:0] rate);
    logic [63:0] whole;
    logic [127:0] sum;
    whole = elapsed / NS_PER_SEC;
    if (rate != 0 && whole >= 64'h1_0000_0000) return {30'd0, REFILL_CAP};
    sum = 128'(whole) * rate + (128'(elapsed % NS_PER_SEC) * rate) / NS_PER_SEC;
    if (sum > 128'(REFILL_CAP)) return {30'd0, REFILL_CAP};
    return sum[63:0];
  endfunction

  task automatic predict_item();
    verdict_t    r;
    logic        hit;
    int          m;
    logic [63:0] elapsed, add, t;
    logic        drop;
    r = '{1'b0, CAUSE_NONE, 64'd0, 32'd0};
    hit = 1'b0;
    m = 0;
    if (mode_t'(in_mode) == MODE_PKT && in_ipv4_ok) begin
      for (int i = 15; i >= 0; i--)
        if (table_q[i].valid && table_q[i].key == in_src_ip) begin
          hit = 1'b1;
          m = i;
        end
      counters[ST_TOTAL]++;
      drop = 1'b0;
      if (hit && table_q[m].blocked) begin
        r.verdict = 1'b1;
        r.cause = CAUSE_BLOCKED;
        counters[ST_BLOCKED]++;
        counters[ST_BYTES_DROP] += in_pkt_len;
      end else begin
        if (hit && table_q[m].limited) begin
          elapsed = (in_now_ns > table_q[m].last) ? in_now_ns - table_q[m].last : 64'd0;
          add = refill_tokens(elapsed, table_q[m].rate);
          if (add != 0) begin
            t = table_q[m].tokens + add;
            if (t > table_q[m].burst) t = table_q[m].burst;
            table_q[m].tokens = t[31:0];
            table_q[m].last = in_now_ns;
          end
          if (table_q[m].tokens == 0) drop = 1'b1;
          else begin
            table_q[m].tokens--;
            r.left = table_q[m].tokens;
          end
        end
        if (drop) begin
          r.verdict = 1'b1;
          r.cause = CAUSE_TOKENS;
          counters[ST_LIMITED]++;
          counters[ST_BYTES_DROP] += in_pkt_len;
        end else begin
          counters[ST_ALLOWED]++;
          counters[ST_BYTES_OK] += in_pkt_len;
        end
      end
    end else if (mode_t'(in_mode) == MODE_WRITE) begin
      table_q[in_slot].valid = in_block_flag | in_limit_enable;
      table_q[in_slot].key = in_src_ip;
      table_q[in_slot].blocked = in_block_flag;
      table_q[in_slot].limited = in_limit_enable;
      table_q[in_slot].rate = in_rate;
      table_q[in_slot].burst = in_burst;
      table_q[in_slot].tokens = (in_start_tokens > in_burst) ? in_burst : in_start_tokens;
      table_q[in_slot].last = in_now_ns;
    end else if (mode_t'(in_mode) == MODE_READ) begin
      if (in_stat_select < NUM_STATS) r.value = counters[in_stat_select];
    end
    verdict_q.push_back(r);
  endtask

  always @(posedge clk) begin
    verdict_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) table_q[i] = '0;
      for (int i = 0; i < NUM_STATS; i++) counters[i] = '0;
      verdict_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) predict_item();
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("result with no item waiting");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = verdict_q.pop_front();
          if (out_verdict !== exp_r.verdict || out_drop_cause !== exp_r.cause ||
              out_stat_value !== exp_r.value || out_tokens_left !== exp_r.left) begin
            if (out_verdict !== exp_r.verdict)
              $error("verdict expected %0d actual %0d", exp_r.verdict, out_verdict);
            if (out_drop_cause !== exp_r.cause)
              $error("drop_cause expected %0d actual %0d", exp_r.cause, out_drop_cause);
            if (out_stat_value !== exp_r.value)
              $error("stat_value expected %0d actual %0d", exp_r.value, out_stat_value);
            if (out_tokens_left !== exp_r.left)
              $error("tokens_left expected %0d actual %0d", exp_r.left, out_tokens_left);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/tb_top.sv
// Top of the filter testbench: clock, reset, directed and random items, random stalls.
// Depends on ibtb_pkg, ibtb_checker and ip_blocklist_token_bucket_filter.
`timescale 1ns / 1ps
module tb_top;
  import ibtb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_src_ip = '0;
  logic [15:0] in_pkt_len = '0;
  logic [63:0] in_now_ns = '0;
  logic        in_ipv4_ok = 1'b0;
  logic [3:0]  in_slot = '0;
  logic        in_block_flag = 1'b0;
  logic        in_limit_enable = 1'b0;
  logic [31:0] in_rate = '0;
  logic [31:0] in_burst = '0;
  logic [31:0] in_start_tokens = '0;
  logic [2:0]  in_stat_select = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        out_verdict;
  logic [1:0]  out_drop_cause;
  logic [63:0] out_stat_value;
  logic [31:0] out_tokens_left;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  logic [31:0] keys[8];
  logic [63:0] clock_ns = 64'd1000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ip_blocklist_token_bucket_filter i_dut (.*);

  ibtb_checker i_checker (.*);

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(60);
  endfunction

  // Random receiver stalls, with calm stretches.
  initial begin
    int calm;
    calm = 0;
    forever begin
      @(negedge clk);
      if (calm > 0) begin
        calm--;
        out_stall <= 1'b0;
      end else if ($urandom_range(99) == 0) begin
        calm = 300;
        out_stall <= 1'b0;
      end else
        out_stall <= ($urandom_range(9) < 3) ? 1'b1 : ($urandom_range(199) == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(mode_t mode, logic [31:0] ip, logic [15:0] len, logic [63:0] now,
                           logic v4, logic [3:0] slot, logic blk, logic lim,
                           logic [31:0] rate, logic [31:0] burst, logic [31:0] start,
                           logic [2:0] sel);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_src_ip <= ip;
    in_pkt_len <= len;
    in_now_ns <= now;
    in_ipv4_ok <= v4;
    in_slot <= slot;
    in_block_flag <= blk;
    in_limit_enable <= lim;
    in_rate <= rate;
    in_burst <= burst;
    in_start_tokens <= start;
    in_stat_select <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet(logic [31:0] ip, logic [15:0] len, logic [63:0] now, logic v4);
    send_item(MODE_PKT, ip, len, now, v4, 4'($urandom), 1'($urandom), 1'($urandom),
              $urandom, $urandom, $urandom, 3'($urandom));
  endtask

  task automatic send_write(logic [3:0] slot, logic [31:0] ip, logic blk, logic lim,
                            logic [31:0] rate, logic [31:0] burst, logic [31:0] start,
                            logic [63:0] now);
    send_item(MODE_WRITE, ip, 16'($urandom), now, 1'($urandom), slot, blk, lim, rate, burst,
              start, 3'($urandom));
  endtask

  task automatic send_read(logic [2:0] sel);
    send_item(MODE_READ, $urandom, 16'($urandom), {$urandom, $urandom}, 1'($urandom),
              4'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom, sel);
  endtask

  function automatic logic [31:0] pick_32();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(3);
      3: return $urandom_range(20);
      4: return $urandom_range(2000000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] advance_ns();
    case ($urandom_range(7))
      0: clock_ns = clock_ns - $urandom_range(5000);
      1: clock_ns = clock_ns + {$urandom, $urandom};
      2: clock_ns = clock_ns + 64'd1000000000 * $urandom_range(3);
      3: clock_ns = {$urandom, $urandom};
      default: clock_ns = clock_ns + $urandom_range(400000000);
    endcase
    return clock_ns;
  endfunction

  initial begin
    int kind;
    for (int i = 0; i < 8; i++) keys[i] = $urandom;
    keys[0] = 32'd0;
    keys[1] = 32'hFFFF_FFFF;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    send_packet(keys[2], 16'hFFFF, 64'd0, 1'b1);
    send_packet(keys[2], 16'd60, 64'd5, 1'b0);
    send_write(4'd0, keys[2], 1'b1, 1'b0, 0, 0, 0, 64'd0);
    send_write(4'd3, keys[2], 1'b0, 1'b1, 32'd1000000000, 32'd2, 32'd9, 64'd0);
    send_packet(keys[2], 16'd100, 64'd1, 1'b1);
    send_write(4'd0, keys[2], 1'b0, 1'b0, 0, 0, 0, 64'd0);
    send_packet(keys[2], 16'd100, 64'd1, 1'b1);
    send_packet(keys[2], 16'd100, 64'd0, 1'b1);
    send_packet(keys[2], 16'd100, 64'd0, 1'b1);
    send_packet(keys[2], 16'd100, 64'd10, 1'b1);
    send_write(4'd15, keys[1], 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 64'd0);
    send_packet(keys[1], 16'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_write(4'd7, keys[0], 1'b0, 1'b1, 32'd3, 32'd5, 32'd0, 64'd0);
    send_packet(keys[0], 16'd1, 64'd300000000, 1'b1);
    send_packet(keys[0], 16'd1, 64'd400000000, 1'b1);
    send_item(MODE_NONE, keys[0], 16'd1, 64'd0, 1'b1, 4'd7, 1'b1, 1'b1, 1, 1, 1, 3'd0);
    for (int s = 0; s < 8; s++) send_read(s[2:0]);

    for (int n = 0; n < 1950; n++) begin
      if (n == 900) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      kind = $urandom_range(99);
      if (kind < 8)
        send_write(4'($urandom), keys[3'($urandom_range(7))], $urandom_range(3) == 0,
                   $urandom_range(3) != 0, pick_32(), pick_32(), pick_32(), advance_ns());
      else if (kind < 16)
        send_read(3'($urandom_range(7)));
      else if (kind < 19)
        send_item(MODE_NONE, $urandom, 16'($urandom), {$urandom, $urandom}, 1'($urandom),
                  4'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                  3'($urandom));
      else if (kind < 90)
        send_packet(keys[3'($urandom_range(7))], 16'($urandom), advance_ns(),
                    $urandom_range(9) != 0);
      else
        send_packet($urandom, 16'($urandom), advance_ns(), 1'($urandom));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
